@@ rtl/core/fir_convolution_stream_macros.svh @@
// Assertion shorthands shared by the FIR convolution block.
// Each macro expands to one labeled concurrent assertion on the rising
// clock edge, switched off while reset is high.
`ifndef FIR_CONVOLUTION_STREAM_MACROS_SVH
`define FIR_CONVOLUTION_STREAM_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define FCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define FCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fcs_pkg.sv @@
package fcs_pkg;

  localparam int MAX_TAPS_DEFAULT = 64;

  localparam int SAMPLE_W      = 16;
  localparam int COEFF_W       = 16;
  localparam int ACC_W         = 38;
  localparam int PROD_W        = SAMPLE_W + COEFF_W;
  localparam int TAP_INDEX_W   = 6;
  localparam int TAP_COUNT_W   = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [TAP_INDEX_W-1:0]     tap_index_t;
  typedef logic [TAP_COUNT_W-1:0]     tap_count_t;

  // Input word commands.
  typedef enum logic {
    CMD_WRITE_COEFF = 1'b0,
    CMD_SAMPLE      = 1'b1
  } command_t;

  // One output word as held in the output and skid registers.
  typedef struct packed {
    acc_t result;
    logic last_result;
  } result_word_t;

endpackage

@@ rtl/core/fcs_if.sv @@
// Input channel: coefficient writes and samples.
interface fcs_in_if;
  logic                valid;
  logic                ready;
  fcs_pkg::command_t   command;
  fcs_pkg::tap_index_t tap_index;
  fcs_pkg::coeff_t     coeff_value;
  fcs_pkg::sample_t    sample;
  logic                last_sample;

  modport source (
    output valid, command, tap_index, coeff_value, sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, command, tap_index, coeff_value, sample, last_sample,
    output ready
  );
endinterface

// Output channel: convolution results.
interface fcs_out_if;
  logic           valid;
  logic           ready;
  fcs_pkg::acc_t  result;
  logic           last_result;

  modport source (
    output valid, result, last_result,
    input  ready
  );
  modport sink (
    input  valid, result, last_result,
    output ready
  );
endinterface

@@ rtl/core/fcs_cell.sv @@
module fcs_cell #(
  parameter int MAX_TAPS = fcs_pkg::MAX_TAPS_DEFAULT,
  parameter int IDX      = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  fcs_pkg::sample_t                 x,
  input  logic                             coef_we,
  input  fcs_pkg::coeff_t                  coef_wdata,
  input  logic [$clog2(MAX_TAPS+1)-1:0]    tap_count,
  input  fcs_pkg::acc_t                    up_sum,
  output fcs_pkg::acc_t                    sum_out
);
  import fcs_pkg::*;

  coeff_t                    coef;
  logic signed [PROD_W-1:0]  prod;
  acc_t                      sum;
  logic                      use_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (coef_we) begin
      coef <= coef_wdata;
    end
  end

  // The upper neighbor's sum only counts while it lies inside the active taps.
  assign use_up = int'(tap_count) > IDX + 1;
  assign prod   = x * coef;
  assign sum    = (use_up ? up_sum : acc_t'(0)) + ACC_W'(prod);

  if (IDX == 0) begin : g_head
    // The head cell's sum is the output value itself.
    assign sum_out = sum;
  end else begin : g_store
    acc_t ps;
    logic active;

    assign active = int'(tap_count) > IDX;

    always_ff @(posedge clk) begin
      if (rst) begin
        ps <= '0;
      end else if (step) begin
        ps <= active ? sum : acc_t'(0);
      end
    end

    assign sum_out = ps;
  end

endmodule

@@ rtl/core/fir_convolution_stream.sv @@
// Streaming full linear convolution of Q1.15 samples with a loaded impulse
// response of up to MAX_TAPS taps, built as a transposed-form FIR chain of
// cells. Each cell holds one coefficient and, but for the head, one partial
// sum, and every step multiplies the current sample into all cells at once
// while the partial sums move one cell toward the head. A coefficient write
// word gives no result. A sample word's exact 38-bit Q.30 result lands in
// the output register, or in the skid register while one waits. Samples
// stream at one word per cycle while results are drained. A sample word
// marked as last starts a tail flush of tap_count-1 further results, one per
// cycle while the skid register is free, during which the input is held off;
// the final result of the sequence carries last_result and leaves all
// partial sums at zero. An output register plus a skid register let one
// result wait while the next word is taken; input ready drops only when both
// are full or a flush is running. The tap count register is written at any
// cycle the enable is high and should only change while the block is idle;
// zero acts as one and values above MAX_TAPS act as MAX_TAPS. Coefficient
// writes beyond the store are dropped. Reset is synchronous and clears all
// coefficients and sums, with no clearing pass.
`include "fir_convolution_stream_macros.svh"

module fir_convolution_stream #(
  parameter int MAX_TAPS = fcs_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  fcs_in_if.sink               din,
  fcs_out_if.source            dout,
  input  logic                 tap_count_we,
  input  fcs_pkg::tap_count_t  tap_count_wdata
);
  import fcs_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  // Active tap count, kept in its cleaned-up form.
  logic [CNT_W-1:0] active_taps;
  logic [CNT_W-1:0] active_taps_next;

  // Remaining tail results of the flush; nonzero means a flush is running.
  logic [CNT_W-1:0] flush_cnt;
  logic             flushing;

  // Output register and skid register.
  logic         out_valid;
  result_word_t out_word;
  logic         skid_valid;
  result_word_t skid_word;

  logic         in_accept;
  logic         sample_accept;
  logic         coef_accept;
  logic         step;
  logic         pop;
  sample_t      x;
  result_word_t gen_word;

  acc_t links [MAX_TAPS];

  // Clamp the written tap count into the supported range.
  always_comb begin
    priority if (tap_count_wdata == '0) begin
      active_taps_next = CNT_W'(1);
    end else if (int'(tap_count_wdata) > MAX_TAPS) begin
      active_taps_next = CNT_W'(MAX_TAPS);
    end else begin
      active_taps_next = CNT_W'(tap_count_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= CNT_W'(1);
    end else if (tap_count_we) begin
      active_taps <= active_taps_next;
    end
  end

  assign flushing = (flush_cnt != '0);

  // A new word is taken only when the skid register is free and no flush runs.
  assign din.ready     = !skid_valid && !flushing;
  assign in_accept     = din.valid && din.ready;
  assign sample_accept = in_accept && (din.command == CMD_SAMPLE);
  assign coef_accept   = in_accept && (din.command == CMD_WRITE_COEFF);

  // A flush step is a sample step with a zero sample: the chain shifts
  // toward the head and the head cell hands out the next pending sum.
  assign step = sample_accept || (flushing && !skid_valid);
  assign x    = flushing ? sample_t'(0) : din.sample;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cells
    acc_t up;

    if (i + 1 < MAX_TAPS) begin : g_up
      assign up = links[i+1];
    end else begin : g_top
      assign up = '0;
    end

    fcs_cell #(
      .MAX_TAPS (MAX_TAPS),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .x          (x),
      .coef_we    (coef_accept && (int'(din.tap_index) == i)),
      .coef_wdata (din.coeff_value),
      .tap_count  (active_taps),
      .up_sum     (up),
      .sum_out    (links[i])
    );
  end

  // During a flush the last tail result is marked; for a single tap the last
  // sample's own result is the final one.
  always_comb begin
    gen_word.result = links[0];
    if (flushing) begin
      gen_word.last_result = (flush_cnt == CNT_W'(1));
    end else begin
      gen_word.last_result = din.last_sample && (active_taps == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= '0;
    end else if (sample_accept && din.last_sample && (active_taps > CNT_W'(1))) begin
      flush_cnt <= active_taps - CNT_W'(1);
    end else if (flushing && step) begin
      flush_cnt <= flush_cnt - CNT_W'(1);
    end
  end

  // Two-entry output buffer: results land in the output register when it is
  // free or being drained, otherwise in the skid register.
  assign pop = out_valid && dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= step;
      end
    end else if (step) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (step) begin
        out_word <= gen_word;
      end
    end else if (step) begin
      if (out_valid) begin
        skid_word <= gen_word;
      end else begin
        out_word <= gen_word;
      end
    end
  end

  assign dout.valid       = out_valid;
  assign dout.result      = out_word.result;
  assign dout.last_result = out_word.last_result;

  // The skid register is only ever filled behind a waiting output word.
  `FCS_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full with output empty")

  // No input word is taken while a tail flush is running.
  `FCS_ASSERT_NOW(a_no_accept_in_flush, clk, rst, flushing, !din.ready, "input taken during flush")

  // A last sample with more than one tap arms the flush with tap_count-1.
  `FCS_ASSERT_NEXT(a_flush_armed, clk, rst, sample_accept && din.last_sample && (active_taps > CNT_W'(1)), flush_cnt == $past(active_taps) - CNT_W'(1), "flush count not armed")

  // Each flush step produces one result and counts down by one.
  `FCS_ASSERT_NEXT(a_flush_counts, clk, rst, flushing && !skid_valid, (flush_cnt == $past(flush_cnt) - CNT_W'(1)) && out_valid, "flush step lost")

endmodule

@@ verif/fir_convolution_stream_check.sv @@
module fir_convolution_stream_check (
  input  logic                clk,
  input  logic                rst,
  fcs_in_if                   din,
  fcs_out_if                  dout,
  input  logic                tap_count_we,
  input  fcs_pkg::tap_count_t tap_count_wdata,
  output int                  errors,
  output int                  pending
);
  import fcs_pkg::*;

  localparam int NUM_TAPS = MAX_TAPS_DEFAULT;

  coeff_t       impulse [NUM_TAPS];
  acc_t         chain [NUM_TAPS];
  tap_count_t   taps_reg;
  result_word_t expected_outputs [$];
  result_word_t want;
  int           fail_count = 0;

  // Zero selects one tap and anything above the store selects all of them.
  function automatic int unsigned taps_in_use();
    if (taps_reg == 0) return 1;
    if (taps_reg > NUM_TAPS) return NUM_TAPS;
    return 32'(taps_reg);
  endfunction

  function automatic acc_t tap_product(sample_t x, coeff_t h);
    return acc_t'(longint'(x) * longint'(h));
  endfunction

  task automatic expect_word(input acc_t value, input logic last);
    result_word_t word;
    word.result = value;
    word.last_result = last;
    expected_outputs.push_back(word);
  endtask

  // One step of the transposed chain: the head sum plus this sample's first
  // product leaves now, every other sum moves one cell toward the head.
  task automatic convolve_sample(input sample_t x, input logic last);
    int unsigned m;
    acc_t        y;
    acc_t        upper;
    m = taps_in_use();
    y = ((m > 1) ? chain[0] : acc_t'(0)) + tap_product(x, impulse[0]);
    for (int unsigned k = 0; k + 1 < m; k++) begin
      upper = (k + 2 < m) ? chain[k + 1] : acc_t'(0);
      chain[k] = upper + tap_product(x, impulse[k + 1]);
    end
    for (int unsigned k = m - 1; k < NUM_TAPS; k++) chain[k] = '0;
    if (!last) begin
      expect_word(y, 1'b0);
    end else begin
      expect_word(y, m == 1);
      for (int unsigned k = 0; k + 1 < m; k++) expect_word(chain[k], k + 2 == m);
      for (int i = 0; i < NUM_TAPS; i++) chain[i] = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        impulse[i] = '0;
        chain[i] = '0;
      end
      taps_reg = tap_count_t'(1);
      expected_outputs.delete();
    end else begin
      if (tap_count_we) taps_reg = tap_count_wdata;
      if (dout.valid && dout.ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: result word %0d arrived with nothing expected", $time, dout.result);
          fail_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (dout.result !== want.result) begin
            $display("%0t: result mismatch, expected %0d, actual %0d",
                     $time, want.result, dout.result);
            fail_count++;
          end
          if (dout.last_result !== want.last_result) begin
            $display("%0t: last_result mismatch, expected %0b, actual %0b",
                     $time, want.last_result, dout.last_result);
            fail_count++;
          end
        end
      end
      if (din.valid && din.ready) begin
        if (din.command == CMD_WRITE_COEFF) begin
          if (din.tap_index < NUM_TAPS) impulse[din.tap_index] = din.coeff_value;
        end else begin
          convolve_sample(din.sample, din.last_sample);
        end
      end
    end
    errors <= fail_count;
    pending <= expected_outputs.size();
  end

endmodule

@@ verif/fir_convolution_stream_test.sv @@
module fir_convolution_stream_test;
  import fcs_pkg::*;

  // The run is bounded by this many clock cycles, well above the slowest
  // correct run, in which every word could close a sequence of sixty-four taps
  // and every one of its results wait out the longest sink stall, on top of
  // the longest source gap before every word.
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 260;

  logic       clk = 1'b0;
  logic       rst;
  logic       tap_count_we;
  tap_count_t tap_count_wdata;
  int         fail_total;
  int         words_pending;
  int         words_sent = 0;
  int         cycle_count = 0;

  // Idle switches: the source gap is drawn inside the stimulus process, the
  // sink stall inside the always block below.
  bit         src_idle_on = 1'b0;
  bit         sink_idle_on = 1'b0;
  logic       sink_ready = 1'b0;
  int         sink_wait = 0;
  int         stall;

  fcs_in_if  in_ch ();
  fcs_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  fir_convolution_stream dut (
    .clk             (clk),
    .rst             (rst),
    .din             (in_ch),
    .dout            (out_ch),
    .tap_count_we    (tap_count_we),
    .tap_count_wdata (tap_count_wdata)
  );

  fir_convolution_stream_check checker_i (
    .clk             (clk),
    .rst             (rst),
    .din             (in_ch),
    .dout            (out_ch),
    .tap_count_we    (tap_count_we),
    .tap_count_wdata (tap_count_wdata),
    .errors          (fail_total),
    .pending         (words_pending)
  );

  always #5 clk = ~clk;

  // Watchdog. A hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink. After each accepted word it may hold ready low for a drawn
  // number of cycles; with idling off, ready simply stays high.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      sink_wait <= 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) sink_ready <= 1'b1;
    end else if (sink_ready && out_ch.valid) begin
      stall = sink_idle_on ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        sink_ready <= 1'b0;
        sink_wait <= stall;
      end
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Mostly uniform values, with the two extremes and zero mixed in often
  // enough that the products hit their largest magnitudes.
  function automatic logic [15:0] draw_level();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one word and hold it until the block takes it. A gap of zero
  // keeps valid high straight into the next word, so valid is never lowered
  // and raised again at the same edge.
  task automatic send_word(input command_t cmd, input tap_index_t idx, input coeff_t c,
                           input sample_t s, input logic last);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.tap_index <= idx;
    in_ch.coeff_value <= c;
    in_ch.sample <= s;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // The fields that a command does not use carry random bits; the block must
  // ignore them.
  task automatic write_coeff(input tap_index_t idx, input coeff_t c);
    send_word(CMD_WRITE_COEFF, idx, c, sample_t'($urandom), logic'($urandom));
  endtask

  task automatic push_sample(input sample_t s, input logic last);
    send_word(CMD_SAMPLE, tap_index_t'($urandom), coeff_t'($urandom), s, last);
  endtask

  // Stop sending and wait until every expected result has been taken. The
  // first edge lets the checker count the word accepted last.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The tap count only changes while the block holds no result.
  task automatic set_taps(input tap_count_t count);
    wait_drained();
    tap_count_we <= 1'b1;
    tap_count_wdata <= count;
    @(posedge clk);
    tap_count_we <= 1'b0;
  endtask

  // One random phase: a tap count (extremes included), a few coefficient
  // writes, then one to three sequences. A coefficient write sometimes falls
  // inside a sequence, and now and then the final sequence is left open so
  // that the next phase changes the tap count in the middle of it.
  task automatic run_phase();
    tap_count_t  count;
    int unsigned span;
    int unsigned seq_total;
    int unsigned len;
    bit          leave_open;
    case ($urandom_range(0, 9))
      0: count = 0;
      1: count = 1;
      2: count = tap_count_t'(MAX_TAPS_DEFAULT);
      3: count = tap_count_t'($urandom_range(MAX_TAPS_DEFAULT + 1, 127));
      4: count = tap_count_t'($urandom_range(13, MAX_TAPS_DEFAULT));
      default: count = tap_count_t'($urandom_range(2, 12));
    endcase
    span = (count == 0) ? 1 : (count > MAX_TAPS_DEFAULT) ? MAX_TAPS_DEFAULT : count;
    set_taps(count);
    src_idle_on = $urandom_range(0, 3) != 0;
    sink_idle_on <= $urandom_range(0, 3) != 0;
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) write_coeff(tap_index_t'($urandom), draw_level());
      else write_coeff(tap_index_t'($urandom_range(0, span - 1)), draw_level());
    end
    seq_total = $urandom_range(1, 3);
    leave_open = $urandom_range(0, 4) == 0;
    for (int unsigned n = 1; n <= seq_total; n++) begin
      len = $urandom_range(1, 10);
      for (int unsigned i = 1; i <= len; i++) begin
        if ($urandom_range(0, 9) == 0)
          write_coeff(tap_index_t'($urandom_range(0, span - 1)), draw_level());
        push_sample(draw_level(), i == len && !(leave_open && n == seq_total));
      end
    end
  endtask

  initial begin
    int random_start;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_SAMPLE;
    in_ch.tap_index <= '0;
    in_ch.coeff_value <= '0;
    in_ch.sample <= '0;
    in_ch.last_sample <= 1'b0;
    tap_count_we <= 1'b0;
    tap_count_wdata <= '0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side. The tap count is one out
    // of reset and every coefficient is zero.
    push_sample(16'sh7fff, 1'b0);
    write_coeff(0, 16'sh8000);
    // A single tap: the last sample's own result is the final one.
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7fff, 1'b1);

    set_taps(4);
    write_coeff(1, 16'sh7fff);
    write_coeff(2, 16'sh8000);
    write_coeff(3, 16'sh0001);
    write_coeff(63, 16'sh5555);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh0000, 1'b0);
    // A coefficient changed inside a sequence only affects later samples.
    write_coeff(1, 16'sh3039);
    push_sample(16'sh0001, 1'b0);
    // The tap count shrinks inside the open sequence, so the sums beyond the
    // new count are dropped.
    set_taps(2);
    push_sample(-16'sh0001, 1'b1);
    // And grows inside one.
    push_sample(16'sh4000, 1'b0);
    set_taps(5);
    push_sample(-16'sh4000, 1'b1);

    // A count of zero acts as one tap.
    set_taps(0);
    push_sample(16'sh8000, 1'b1);
    // A count above the store acts as the full store, with a long tail.
    set_taps(127);
    write_coeff(63, 16'sh8000);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    set_taps(tap_count_t'(MAX_TAPS_DEFAULT + 1));
    push_sample(16'sh3039, 1'b1);

    // Random part. It opens with the full store loaded with the most
    // negative coefficient and a full-length run of the most negative
    // sample, which drives the sum to its largest magnitude.
    random_start = words_sent;
    set_taps(tap_count_t'(MAX_TAPS_DEFAULT));
    src_idle_on = 1'b1;
    sink_idle_on <= 1'b1;
    for (int i = 0; i < MAX_TAPS_DEFAULT; i++) write_coeff(tap_index_t'(i), 16'sh8000);
    for (int i = 1; i <= MAX_TAPS_DEFAULT; i++) push_sample(16'sh8000, i == MAX_TAPS_DEFAULT);
    while (words_sent < random_start + RANDOM_WORDS) run_phase();

    // Close any sequence the last phase left open, then let everything drain.
    push_sample(draw_level(), 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_total == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fcs_pkg.sv
rtl/core/fcs_if.sv
rtl/core/fcs_cell.sv
rtl/core/fir_convolution_stream.sv
verif/fir_convolution_stream_check.sv
verif/fir_convolution_stream_test.sv
